### rtl/ipnc_pkg.sv
package ipnc_pkg;

   localparam int ENTRIES = 16;
   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_CREATE = 3'd1,
      OP_UPDATE = 3'd2,
      OP_LEARN  = 3'd3,
      OP_ADVERT = 3'd4,
      OP_TICK   = 3'd5
   } op_type;

   localparam logic [1:0] ST_INC = 2'd0;
   localparam logic [1:0] ST_REA = 2'd1;
   localparam logic [1:0] ST_STA = 2'd2;

   localparam logic [1:0] KIND_REPLY   = 2'd0;
   localparam logic [1:0] KIND_SOLICIT = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_NOTF  = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   localparam logic [1:0] CSR_RETX  = 2'd0;
   localparam logic [1:0] CSR_REACH = 2'd1;
   localparam logic [1:0] CSR_MAXS  = 2'd2;

   typedef struct packed {
      logic        valid;
      logic [63:0] ip_high;
      logic [63:0] ip_low;
      logic [47:0] hw;
      logic [2:0]  iface;
      logic [1:0]  reach;
      logic        router;
      logic [15:0] expiry;
      logic [3:0]  retry;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_APPLY,
      S_EMIT,
      S_DONE
   } state_type;

endpackage

### rtl/ipv6_neighbor_cache_core.sv
// Neighbor cache on a ring of ENTRIES cells. A lookup, create, update, learn or advert
// request takes two rotations of the ring, one to search and one to write back, and
// its reply is loaded after the write-back. A tick walks the ring once, and each
// stalled solicit or drop result holds the walk; its done result follows the walk.
// The next request is taken only after the previous reply or done result is loaded.
// A request is taken only once the last result can leave. Reset empties the table and
// loads the register defaults; no clearing pass is needed.
module ipv6_neighbor_cache_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_ip_high,
   input  logic [63:0] req_ip_low,
   input  logic [47:0] req_hw_addr,
   input  logic        req_hw_valid,
   input  logic [2:0]  req_iface,
   input  logic [1:0]  req_reach_state_in,
   input  logic        req_is_router,
   input  logic        req_router_valid,
   input  logic        req_solicited,
   input  logic        req_tlla_present,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_index,
   output logic [1:0]  rsp_reach_state,
   output logic [47:0] rsp_hw_out,
   output logic        rsp_router_out,
   output logic [2:0]  rsp_iface_out,
   output logic [63:0] rsp_entry_ip_high,
   output logic [63:0] rsp_entry_ip_low,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int CNT_W = ipnc_pkg::SLOT_W + 1;

   ipnc_pkg::entry_type ring_q [ipnc_pkg::ENTRIES];
   ipnc_pkg::entry_type head_new;
   logic                shift;

   for (genvar g = 0; g < ipnc_pkg::ENTRIES; g++) begin : g_cell
      ipnc_pkg::entry_type cin;
      if (g == ipnc_pkg::ENTRIES - 1) begin : g_tail
         assign cin = head_new;
      end else begin : g_mid
         assign cin = ring_q[g + 1];
      end
      ipnc_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .entry_in(cin), .entry_out(ring_q[g])
      );
   end

   logic [15:0] retx_ff, reach_ff;
   logic [3:0]  maxs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retx_ff  <= 16'd1000;
         reach_ff <= 16'd30000;
         maxs_ff  <= 4'd3;
      end else if (csr_write) begin
         case (csr_index)
            ipnc_pkg::CSR_RETX:  retx_ff  <= csr_data;
            ipnc_pkg::CSR_REACH: reach_ff <= csr_data[15:0];
            ipnc_pkg::CSR_MAXS:  maxs_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Captured request.
   logic [2:0]  op_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [47:0] hw_ff;
   logic        hwv_ff, rtr_ff, rv_ff, sol_ff, tlla_ff;
   logic [2:0]  ifc_ff;
   logic [1:0]  rst_ff;

   // Walk bookkeeping. The slot number at the head equals the walk count.
   ipnc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [ipnc_pkg::SLOT_W-1:0] fslot_ff, fslot_in;
   logic              free_ff, free_in;
   logic [ipnc_pkg::SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic              done_ff, done_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in, status_ff, status_in;
   logic [3:0] idx_ff, idx_in;
   ipnc_pkg::entry_type rent_ff, rent_in;
   logic last_ff, last_in;

   ipnc_pkg::entry_type head;
   logic [ipnc_pkg::SLOT_W-1:0] slot;
   logic match, is_tick, is_create, emit_tick, out_free;

   assign head     = ring_q[0];
   assign slot     = cnt_ff[ipnc_pkg::SLOT_W-1:0];
   assign match    = head.valid && head.ip_high == hi_ff && head.ip_low == lo_ff;
   assign is_tick  = op_ff == ipnc_pkg::OP_TICK;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // The result register is reused by the next request, so the last result must leave.
   assign req_ready = state_ff == ipnc_pkg::S_IDLE && out_free;
   // In the second pass a create, or a learn that saw no match, writes the free slot.
   assign is_create = op_ff == ipnc_pkg::OP_CREATE ||
                      (op_ff == ipnc_pkg::OP_LEARN && !found_ff);

   // Per-head modification and tick emission.
   always_comb begin
      head_new  = head;
      emit_tick = 1'b0;
      kind_in   = kind_ff;
      if (state_ff == ipnc_pkg::S_WALK && is_tick) begin
         if (head.valid && head.reach == ipnc_pkg::ST_INC) begin
            if (head.expiry != 16'd0) begin
               head_new.expiry = head.expiry - 16'd1;
            end else if (head.retry < maxs_ff) begin
               head_new.retry  = head.retry + 4'd1;
               head_new.expiry = retx_ff;
               emit_tick       = 1'b1;
               kind_in         = ipnc_pkg::KIND_SOLICIT;
            end else begin
               head_new.valid  = 1'b0;
               emit_tick       = 1'b1;
               kind_in         = ipnc_pkg::KIND_DROP;
            end
         end
      end else if (state_ff == ipnc_pkg::S_APPLY) begin
         if (is_create && free_ff && slot == free_slot_ff) begin
            head_new.valid   = 1'b1;
            head_new.ip_high = hi_ff;
            head_new.ip_low  = lo_ff;
            head_new.retry   = 4'd0;
            if (op_ff == ipnc_pkg::OP_CREATE) begin
               head_new.hw     = hwv_ff ? hw_ff : 48'd0;
               head_new.iface  = ifc_ff;
               head_new.reach  = (rst_ff == 2'd3) ? ipnc_pkg::ST_STA : rst_ff;
               head_new.router = rtr_ff;
            end else begin
               head_new.hw     = hw_ff;
               head_new.iface  = ifc_ff;
               head_new.reach  = ipnc_pkg::ST_STA;
               head_new.router = 1'b0;
            end
            head_new.expiry = (head_new.reach == ipnc_pkg::ST_INC) ? retx_ff : reach_ff;
         end else if (found_ff && slot == fslot_ff) begin
            case (op_ff)
               ipnc_pkg::OP_UPDATE, ipnc_pkg::OP_LEARN: begin
                  if (head.hw != hw_ff) begin
                     head_new.hw    = hw_ff;
                     head_new.reach = ipnc_pkg::ST_STA;
                  end
                  if (op_ff == ipnc_pkg::OP_UPDATE && rv_ff) begin
                     head_new.router = rtr_ff;
                  end
               end
               ipnc_pkg::OP_ADVERT: begin
                  if (head.reach == ipnc_pkg::ST_INC && tlla_ff) begin
                     // An unsolicited advertisement marks the entry stale and takes its link-layer address
                     // only when that address differs; with the router flag it still sets the router bit.
                     if (sol_ff) begin
                        head_new.hw    = hw_ff;
                        head_new.reach = ipnc_pkg::ST_REA;
                     end else if (head.hw != hw_ff) begin
                        head_new.hw    = hw_ff;
                        head_new.reach = ipnc_pkg::ST_STA;
                     end
                     if (sol_ff || rtr_ff) begin
                        head_new.router = rtr_ff | !sol_ff;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign shift = (state_ff == ipnc_pkg::S_WALK && (!emit_tick || out_free)) ||
                  state_ff == ipnc_pkg::S_APPLY;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipnc_pkg::S_IDLE:
            if (req_valid && req_ready) state_in = ipnc_pkg::S_WALK;
         ipnc_pkg::S_WALK:
            if (shift && cnt_ff == CNT_W'(ipnc_pkg::ENTRIES - 1)) begin
               state_in = is_tick ? ipnc_pkg::S_DONE : ipnc_pkg::S_APPLY;
            end
         ipnc_pkg::S_APPLY:
            if (cnt_ff == CNT_W'(ipnc_pkg::ENTRIES - 1)) state_in = ipnc_pkg::S_EMIT;
         ipnc_pkg::S_EMIT:
            if (done_ff) state_in = ipnc_pkg::S_IDLE;
         ipnc_pkg::S_DONE:
            if (out_free) state_in = ipnc_pkg::S_IDLE;
         default: state_in = ipnc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      fslot_in     = fslot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      idx_in       = idx_ff;
      rent_in      = rent_ff;
      last_in      = last_ff;
      case (state_ff)
         ipnc_pkg::S_IDLE: begin
            cnt_in   = '0;
            found_in = 1'b0;
            free_in  = 1'b0;
            done_in  = 1'b0;
         end
         ipnc_pkg::S_WALK: begin
            if (shift) begin
               cnt_in = (cnt_ff == CNT_W'(ipnc_pkg::ENTRIES - 1)) ? '0 : cnt_ff + 1'b1;
               if (match && !found_ff) begin
                  found_in = 1'b1;
                  fslot_in = slot;
               end
               if (!head.valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = slot;
               end
            end
            if (emit_tick && out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ipnc_pkg::STS_OK;
               idx_in       = 4'(slot);
               rent_in      = head;
               last_in      = 1'b0;
            end
         end
         ipnc_pkg::S_APPLY: begin
            cnt_in = cnt_ff + 1'b1;
            // Capture the entry concerned as it is written back.
            if ((is_create && free_ff && slot == free_slot_ff) ||
                (!is_create && found_ff && slot == fslot_ff)) begin
               rent_in = head_new;
            end
         end
         ipnc_pkg::S_EMIT: begin
            if (out_free && !done_ff) begin
               done_in      = 1'b1;
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               if (op_ff > ipnc_pkg::OP_ADVERT) begin
                  status_in = ipnc_pkg::STS_NOTF;
                  idx_in    = '0;
                  rent_in   = '0;
               end else if (is_create) begin
                  status_in = free_ff ? ipnc_pkg::STS_OK : ipnc_pkg::STS_FULL;
                  idx_in    = free_ff ? 4'(free_slot_ff) : 4'd0;
                  if (!free_ff) rent_in = '0;
               end else begin
                  status_in = found_ff ? ipnc_pkg::STS_OK : ipnc_pkg::STS_NOTF;
                  idx_in    = found_ff ? 4'(fslot_ff) : 4'd0;
                  if (!found_ff) rent_in = '0;
               end
            end
         end
         ipnc_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = ipnc_pkg::STS_OK;
               idx_in       = '0;
               rent_in      = '0;
               last_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   logic [1:0] kind_sel;
   always_comb begin
      kind_sel = kind_in;
      if (state_ff == ipnc_pkg::S_EMIT) kind_sel = ipnc_pkg::KIND_REPLY;
      if (state_ff == ipnc_pkg::S_DONE) kind_sel = ipnc_pkg::KIND_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipnc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         done_ff      <= done_in;
      end
      fslot_ff     <= fslot_in;
      free_slot_ff <= free_slot_in;
      status_ff    <= status_in;
      idx_ff       <= idx_in;
      rent_ff      <= rent_in;
      last_ff      <= last_in;
      if (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) kind_ff <= kind_sel;
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         hi_ff   <= req_ip_high;
         lo_ff   <= req_ip_low;
         hw_ff   <= req_hw_addr;
         hwv_ff  <= req_hw_valid;
         ifc_ff  <= req_iface;
         rst_ff  <= req_reach_state_in;
         rtr_ff  <= req_is_router;
         rv_ff   <= req_router_valid;
         sol_ff  <= req_solicited;
         tlla_ff <= req_tlla_present;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_status        = status_ff;
   assign rsp_index         = idx_ff;
   assign rsp_reach_state   = rent_ff.reach;
   assign rsp_hw_out        = rent_ff.hw;
   assign rsp_router_out    = rent_ff.router;
   assign rsp_iface_out     = rent_ff.iface;
   assign rsp_entry_ip_high = rent_ff.ip_high;
   assign rsp_entry_ip_low  = rent_ff.ip_low;
   assign rsp_last          = last_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_last)
      else $error("request taken while a non-final result is pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result dropped under stall");
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == ipnc_pkg::KIND_DONE |-> rsp_index == 4'd0 && rsp_last)
      else $error("tick done result malformed");
endmodule

### rtl/ipnc_cell.sv
// One table entry. Entries rotate through the ring: each cycle that shift is high a cell
// takes its neighbor's entry, while the entry leaving the ring head may be replaced.
module ipnc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  ipnc_pkg::entry_type  entry_in,
   output ipnc_pkg::entry_type  entry_out
);
   ipnc_pkg::entry_type entry_ff;
   logic                valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= entry_in.valid;
      end
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      entry_out       = entry_ff;
      entry_out.valid = valid_ff;
   end
endmodule
